@@ hdl/dilp_pkg.sv @@
// Shared types and constants for the decimal id list parser.
// No dependencies; every other file in hdl uses it by scoped names.
package dilp_pkg;

    // default limit on values per string
    localparam int MAX_VALUES_DEF = 128;

    // result queue depth and pointer width
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DRAIN  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SYNTAX = 2'd1,
        ST_RANGE  = 2'd2,
        ST_COUNT  = 2'd3
    } status_t;

    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // register index of the mode bit
    localparam logic REG_MODE = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [31:0] id;
        logic [6:0]  idx;
        logic [1:0]  status;
        logic [7:0]  count;
        logic        last;
    } res_t;

    // up to two results pushed per processed byte
    typedef struct packed {
        logic [1:0] num;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

@@ hdl/decimal_id_list_parser_top.sv @@
// Parses a byte stream of whitespace-separated signed decimal numbers into
// 32-bit ids. One byte per input beat, tlast marks the terminator beat (its data is
// ignored). Each byte is taken into an input register and processed from there by a
// single accumulate-by-ten step; one byte per cycle is sustained unless stalled. A value
// beat leaves in list mode when its number ends; each terminator yields one status
// beat (tlast high, tuser high), preceded in single mode by the value when the string
// is valid. A terminator can thus produce two beats, which a four-entry result queue
// absorbs; input stalls only while that queue cannot take two more results.
// Depends on dilp_pkg, dilp_parser and dilp_out_fifo.
module decimal_id_list_parser_top #(
    parameter int MAX_VALUES = dilp_pkg::MAX_VALUES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,   // end_of_string
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] id_value, [38:32] value_index,
                                        // [40:39] parse_status, [48:41] value_count
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast,   // last_result
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_eos_reg;
    logic       mode_reg;

    logic            step;
    logic            room2;
    logic            not_empty;
    dilp_pkg::push_t push;
    dilp_pkg::res_t  head;

    assign step          = in_valid_reg && room2;
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_char_reg <= s_axis_tdata;
            in_eos_reg  <= s_axis_tlast;
        end
    end

    // apb register file: one mode bit
    assign pready = 1'b1;
    assign prdata = (paddr[2] == dilp_pkg::REG_MODE) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == dilp_pkg::REG_MODE) begin
            mode_reg <= pwdata[0];
        end
    end

    dilp_parser #(
        .MAX_VALUES (MAX_VALUES)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .char_byte     (in_char_reg),
        .end_of_string (in_eos_reg),
        .single_mode   (mode_reg),
        .push          (push)
    );

    dilp_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_axis_tvalid && m_axis_tready),
        .room2     (room2),
        .not_empty (not_empty),
        .head      (head)
    );

    assign m_axis_tvalid = not_empty;
    assign m_axis_tdata  = {7'd0, head.count, head.status, head.idx, head.id};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

endmodule

@@ hdl/dilp_parser.sv @@
// Parser state and the per-byte step logic of the decimal id list parser.
// Depends on dilp_pkg for phase, status and result types.
module dilp_parser #(
    parameter int MAX_VALUES = dilp_pkg::MAX_VALUES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      char_byte,
    input  logic            end_of_string,
    input  logic            single_mode,
    output dilp_pkg::push_t push
);

    localparam int CNT_W = $clog2(MAX_VALUES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VALUES);

    dilp_pkg::phase_t phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [31:0]      acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic [1:0]       err_reg, err_next;

    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit_val;
    logic [35:0] prod;
    logic [31:0] signed_val;
    logic        range_bad;

    dilp_pkg::push_t p;

    assign is_digit  = (char_byte >= dilp_pkg::CHAR_ZERO) && (char_byte <= dilp_pkg::CHAR_NINE);
    assign is_space  = (char_byte == dilp_pkg::CHAR_SPACE) ||
                       ((char_byte >= dilp_pkg::CHAR_TAB) && (char_byte <= dilp_pkg::CHAR_CR));
    assign digit_val = char_byte[3:0];
    // acc * 10 + d
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 36'(digit_val);
    assign signed_val = neg_reg ? (32'd0 - acc_reg) : acc_reg;
    assign range_bad  = ovf_reg || (neg_reg && (acc_reg > dilp_pkg::NEG_LIMIT));

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        p          = '0;

        // a number ends at any non-digit or at the terminator
        if (phase_reg == dilp_pkg::PH_DIGITS && (end_of_string || !is_digit)) begin
            if (range_bad) begin
                err_next   = dilp_pkg::ST_RANGE;
                phase_next = dilp_pkg::PH_DRAIN;
            end else begin
                phase_next = dilp_pkg::PH_IDLE;
                if (single_mode) begin
                    seen_next = CNT_W'(1);
                end else begin
                    p.num       = 2'd1;
                    p.r0.kind   = dilp_pkg::KIND_VALUE;
                    p.r0.id     = signed_val;
                    p.r0.idx    = 7'(seen_reg);
                    if (seen_reg < CNT_MAX) begin
                        seen_next = seen_reg + CNT_W'(1);
                    end
                end
            end
        end

        if (!end_of_string) begin
            case (phase_reg)
                dilp_pkg::PH_DIGITS: begin
                    if (is_digit && !ovf_reg) begin
                        if (prod[35:32] != 4'd0) begin
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = prod[31:0];
                        end
                    end
                end
                dilp_pkg::PH_SIGN: begin
                    if (is_digit) begin
                        acc_next   = 32'(digit_val);
                        phase_next = dilp_pkg::PH_DIGITS;
                    end else begin
                        err_next   = dilp_pkg::ST_SYNTAX;
                        phase_next = dilp_pkg::PH_DRAIN;
                    end
                end
                default: begin
                end
            endcase

            // start of a possible number
            if ((phase_reg == dilp_pkg::PH_IDLE ||
                 (phase_reg == dilp_pkg::PH_DIGITS && !is_digit)) &&
                phase_next == dilp_pkg::PH_IDLE && !is_space) begin
                if (single_mode && seen_next != '0) begin
                    err_next   = dilp_pkg::ST_SYNTAX;
                    phase_next = dilp_pkg::PH_DRAIN;
                end else if (!single_mode && seen_next >= CNT_MAX) begin
                    err_next   = dilp_pkg::ST_COUNT;
                    phase_next = dilp_pkg::PH_DRAIN;
                end else begin
                    ovf_next = 1'b0;
                    acc_next = 32'd0;
                    neg_next = (char_byte == dilp_pkg::CHAR_MINUS);
                    if (char_byte == dilp_pkg::CHAR_MINUS || char_byte == dilp_pkg::CHAR_PLUS) begin
                        phase_next = dilp_pkg::PH_SIGN;
                    end else if (is_digit) begin
                        acc_next   = 32'(digit_val);
                        phase_next = dilp_pkg::PH_DIGITS;
                    end else begin
                        err_next   = dilp_pkg::ST_SYNTAX;
                        phase_next = dilp_pkg::PH_DRAIN;
                    end
                end
            end
        end else begin
            if (phase_reg == dilp_pkg::PH_SIGN) begin
                err_next = dilp_pkg::ST_SYNTAX;
            end

            // single mode emits its one value only on a clean string
            if (err_next == dilp_pkg::ST_OK && single_mode) begin
                if (seen_next == '0) begin
                    err_next = dilp_pkg::ST_SYNTAX;
                end else begin
                    p.num     = 2'd1;
                    p.r0.kind = dilp_pkg::KIND_VALUE;
                    p.r0.id   = signed_val;
                end
            end

            if (p.num == 2'd0) begin
                p.r0.kind   = dilp_pkg::KIND_STATUS;
                p.r0.status = err_next;
                p.r0.count  = 8'(seen_next);
                p.r0.last   = 1'b1;
            end else begin
                p.r1.kind   = dilp_pkg::KIND_STATUS;
                p.r1.status = err_next;
                p.r1.count  = 8'(seen_next);
                p.r1.last   = 1'b1;
            end
            p.num = p.num + 2'd1;

            phase_next = dilp_pkg::PH_IDLE;
            neg_next   = 1'b0;
            acc_next   = 32'd0;
            ovf_next   = 1'b0;
            seen_next  = '0;
            err_next   = dilp_pkg::ST_OK;
        end

        if (!step) begin
            p.num = 2'd0;
        end
    end

    assign push = p;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= dilp_pkg::PH_IDLE;
            neg_reg   <= 1'b0;
            acc_reg   <= 32'd0;
            ovf_reg   <= 1'b0;
            seen_reg  <= '0;
            err_reg   <= dilp_pkg::ST_OK;
        end else if (step) begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
        end
    end

endmodule

@@ hdl/dilp_out_fifo.sv @@
// Small result queue between the parser step and the output channel.
// Takes up to two results per cycle; depends on dilp_pkg for res_t/push_t.
module dilp_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  dilp_pkg::push_t push,
    input  logic            pop,
    output logic            room2,
    output logic            not_empty,
    output dilp_pkg::res_t  head
);

    localparam int CNT_W = dilp_pkg::FIFO_PTR_W + 1;

    dilp_pkg::res_t                mem_reg [dilp_pkg::FIFO_DEPTH];
    logic [dilp_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dilp_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [dilp_pkg::FIFO_PTR_W-1:0] wr_ptr_inc;

    assign wr_ptr_inc = wr_ptr_reg + dilp_pkg::FIFO_PTR_W'(1);
    assign not_empty  = (count_reg != '0);
    assign room2      = (count_reg <= CNT_W'(dilp_pkg::FIFO_DEPTH - 2));
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        rd_ptr_next = rd_ptr_reg + dilp_pkg::FIFO_PTR_W'(pop);
        wr_ptr_next = wr_ptr_reg + dilp_pkg::FIFO_PTR_W'(push.num);
        count_next  = count_reg + CNT_W'(push.num) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.num == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push.r1;
        end
    end

endmodule

@@ tb/dilp_checker.sv @@
`timescale 1ns / 100ps
// Checker for the decimal id list parser: follows the byte, result and config channels,
// predicts the id and status beats of each string and compares them in order.
// Depends on dilp_pkg.
module dilp_checker #(
    parameter int MAX_VALUES = dilp_pkg::MAX_VALUES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,   // end_of_string
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // [31:0] id_value, [38:32] value_index,
                                        // [40:39] parse_status, [48:41] value_count
    input  logic        m_axis_tuser,   // result_kind
    input  logic        m_axis_tlast,   // last_result
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          n_pending,
    output int          n_ids,
    output int          n_strings,
    output logic [3:0]  status_seen
);
    import dilp_pkg::*;

    localparam logic [2:0] ADDR_MODE = 3'(4 * int'(REG_MODE));

    res_t owed_results[$];

    // shadow of the parser
    logic        single_mode;
    phase_t      phase;
    logic        negative;
    logic [32:0] magnitude;
    logic        too_big;
    int          values_done;
    status_t     str_status;

    function automatic void owe(logic kind, logic [31:0] id, int idx, status_t st, int cnt,
                                logic last);
        res_t r;
        r.kind   = kind;
        r.id     = id;
        r.idx    = idx[6:0];
        r.status = st;
        r.count  = cnt[7:0];
        r.last   = last;
        owed_results.push_back(r);
    endfunction

    function automatic void clear_string();
        phase       = PH_IDLE;
        negative    = 1'b0;
        magnitude   = '0;
        too_big     = 1'b0;
        values_done = 0;
        str_status  = ST_OK;
    endfunction

    function automatic void abort(status_t st);
        str_status = st;
        phase      = PH_DRAIN;
    endfunction

    function automatic logic [31:0] as_id();
        return negative ? (32'd0 - magnitude[31:0]) : magnitude[31:0];
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic void add_digit(logic [3:0] d);
        logic [36:0] n;
        // once past 32 bits the magnitude is frozen, only the flag matters
        if (!too_big) begin
            n = 37'(magnitude) * 37'd10 + 37'(d);
            if (n > 37'hFFFF_FFFF)
                too_big = 1'b1;
            else
                magnitude = n[32:0];
        end
    endfunction

    function automatic void end_number();
        if (too_big || (negative && magnitude > 33'(NEG_LIMIT))) begin
            abort(ST_RANGE);
        end else begin
            phase = PH_IDLE;
            if (single_mode) begin
                values_done = 1;
            end else begin
                owe(KIND_VALUE, as_id(), values_done, ST_OK, 0, 1'b0);
                if (values_done < MAX_VALUES)
                    values_done++;
            end
        end
    endfunction

    function automatic void start_token(logic [7:0] c);
        if (!is_ws(c)) begin
            if (single_mode && values_done >= 1) begin
                abort(ST_SYNTAX);
            end else if (!single_mode && values_done >= MAX_VALUES) begin
                abort(ST_COUNT);
            end else begin
                magnitude = '0;
                too_big   = 1'b0;
                negative  = (c == CHAR_MINUS);
                if (c == CHAR_MINUS || c == CHAR_PLUS) begin
                    phase = PH_SIGN;
                end else if (is_digit(c)) begin
                    magnitude = 33'(c - CHAR_ZERO);
                    phase     = PH_DIGITS;
                end else begin
                    abort(ST_SYNTAX);
                end
            end
        end
    endfunction

    function automatic void parse_beat(logic [7:0] c, logic term);
        if (!term) begin
            case (phase)
                PH_DIGITS: begin
                    if (is_digit(c)) begin
                        add_digit(4'(c - CHAR_ZERO));
                    end else begin
                        end_number();
                        if (phase == PH_IDLE)
                            start_token(c);
                    end
                end
                PH_SIGN: begin
                    if (is_digit(c)) begin
                        magnitude = 33'(c - CHAR_ZERO);
                        phase     = PH_DIGITS;
                    end else begin
                        abort(ST_SYNTAX);
                    end
                end
                PH_IDLE: start_token(c);
                default: ;
            endcase
        end else begin
            if (phase == PH_DIGITS)
                end_number();
            else if (phase == PH_SIGN)
                abort(ST_SYNTAX);
            // single mode holds its one value back until the string is known good
            if (str_status == ST_OK && single_mode) begin
                if (values_done == 0)
                    str_status = ST_SYNTAX;
                else
                    owe(KIND_VALUE, as_id(), 0, ST_OK, 0, 1'b0);
            end
            owe(KIND_STATUS, 32'd0, 0, str_status, values_done, 1'b1);
            clear_string();
        end
    endfunction

    function automatic void compare(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_beat();
        res_t want;
        if (owed_results.size() == 0) begin
            $error("result beat with nothing owed: tuser %0h tdata %0h", m_axis_tuser,
                   m_axis_tdata);
            fail_count++;
        end else begin
            want = owed_results.pop_front();
            compare("result_kind", want.kind, m_axis_tuser);
            compare("id_value", want.id, m_axis_tdata[31:0]);
            compare("value_index", want.idx, m_axis_tdata[38:32]);
            compare("parse_status", want.status, m_axis_tdata[40:39]);
            compare("value_count", want.count, m_axis_tdata[48:41]);
            compare("last_result", want.last, m_axis_tlast);
            if (want.kind == KIND_STATUS) begin
                n_strings++;
                status_seen[want.status] = 1'b1;
            end else begin
                n_ids++;
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            single_mode = 1'b0;
            clear_string();
            owed_results.delete();
            fail_count  = 0;
            n_ids       = 0;
            n_strings   = 0;
            status_seen = '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_MODE)
                single_mode = pwdata[0];
            if (s_axis_tvalid && s_axis_tready)
                parse_beat(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                check_beat();
        end
        n_pending = owed_results.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Top of the parser testbench: clock, reset, byte strings in both modes, config writes
// and result back-pressure; dilp_checker does all prediction and comparison.
// Depends on dilp_pkg, dilp_checker and decimal_id_list_parser_top.
module tb;
    import dilp_pkg::*;

    localparam int ITEMS         = 850;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [2:0] ADDR_MODE = 3'(4 * int'(REG_MODE));

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          n_pending;
    int          n_ids;
    int          n_strings;
    logic [3:0]  status_seen;

    int          cycles;
    int          beats;
    int          burst_left;
    bit          hold_req;
    logic [7:0]  text[$];

    always #5 aclk = ~aclk;

    decimal_id_list_parser_top #(
        .MAX_VALUES (MAX_VALUES_DEF)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dilp_checker #(
        .MAX_VALUES (MAX_VALUES_DEF)
    ) i_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .n_pending     (n_pending),
        .n_ids         (n_ids),
        .n_strings     (n_strings),
        .status_seen   (status_seen)
    );

    // byte side ----------------------------------------------------------------------

    task automatic send_beat(input logic [7:0] c, input logic term);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= term;
        do @(posedge aclk); while (!s_axis_tready);
        beats++;
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // the terminator beat carries junk, which the parser must ignore
    task automatic send_text();
        foreach (text[i])
            send_beat(text[i], 1'b0);
        send_beat(8'($urandom), 1'b1);
        text.delete();
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait (n_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic single);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MODE;
        pwdata  <= {31'($urandom), single};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // string building ---------------------------------------------------------------

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endfunction

    function automatic logic [7:0] ws_char();
        return $urandom_range(0, 1) ? CHAR_SPACE : 8'($urandom_range(CHAR_TAB, CHAR_CR));
    endfunction

    function automatic void put_ws();
        repeat ($urandom_range(1, 3)) text.push_back(ws_char());
    endfunction

    function automatic longint unsigned boundary_value();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return 64'd2147483647;
            2:       return 64'd2147483648;
            3:       return 64'd2147483649;
            4:       return 64'd4294967295;
            5:       return 64'd4294967296;
            6:       return 64'd4294967299;
            default: return 64'd42949672950;
        endcase
    endfunction

    function automatic void put_number(bit first);
        logic [7:0] sign;
        int         r;
        r    = $urandom_range(0, 3);
        sign = (r == 0) ? CHAR_MINUS : (r == 1) ? CHAR_PLUS : 8'd0;
        // a signed number may follow the previous one with no blank, as in 12-3
        if (!first && !(sign != 8'd0 && $urandom_range(0, 3) == 0))
            put_ws();
        if (sign != 8'd0)
            text.push_back(sign);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: put_str($sformatf("%0d", $urandom_range(0, 999)));
            4, 5:       put_str($sformatf("%0d", $urandom));
            6:          put_str($sformatf("%0d", boundary_value()));
            7: begin
                repeat ($urandom_range(1, 12)) text.push_back(CHAR_ZERO);
                put_str($sformatf("%0d", $urandom_range(0, 99999)));
            end
            8: repeat ($urandom_range(11, 24))
                text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            default:    put_str($sformatf("%0d", {$urandom, $urandom}));
        endcase
    endfunction

    function automatic void put_list(bit single);
        int n;
        n = single ? 1 : $urandom_range(1, 6);
        if ($urandom_range(0, 1))
            put_ws();
        for (int i = 0; i < n; i++)
            put_number(i == 0);
        if ($urandom_range(0, 1))
            put_ws();
    endfunction

    function automatic logic [7:0] junk_char();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom);
            1:       return CHAR_PLUS;
            2:       return CHAR_MINUS;
            default: return 8'($urandom_range(8'h3A, 8'h7E));
        endcase
    endfunction

    function automatic void put_long_list(int n);
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                text.push_back(CHAR_SPACE);
            text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
        end
    endfunction

    function automatic void build_string(bit single);
        int k;
        k = $urandom_range(0, 19);
        if (k < 12) begin
            put_list(single);
        end else if (k < 15) begin
            put_list(single);
            text.insert($urandom_range(0, text.size()), junk_char());
        end else if (k < 17) begin
            repeat ($urandom_range(0, 8)) begin
                case ($urandom_range(0, 3))
                    0:       text.push_back(8'($urandom));
                    1:       text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                    2:       text.push_back(ws_char());
                    default: text.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                endcase
            end
        end else if (k == 17) begin
            // sign with no digits after it
            if ($urandom_range(0, 1))
                put_number(1'b1);
            put_ws();
            text.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            if ($urandom_range(0, 1))
                text.push_back(junk_char());
        end else if (!single && $urandom_range(0, 3) == 0) begin
            put_long_list($urandom_range(MAX_VALUES_DEF - 2, MAX_VALUES_DEF + 2));
        end else begin
            put_list(single);
        end
    endfunction

    // result side -------------------------------------------------------------------

    initial begin
        int seg;
        int style;
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                style = $urandom_range(0, 2);
                seg   = $urandom_range(10, 60);
                repeat (seg) begin
                    case (style)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // stimulus ----------------------------------------------------------------------

    initial begin
        int  base;
        int  phase_len;
        int  phase_no;
        bit  single;
        bit  long_done;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_req      = 1'b0;
        beats         = 0;
        burst_left    = 4;
        long_done     = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // list mode corner strings
        write_mode(1'b0);
        put_str("9-8");
        send_text();
        text.push_back(CHAR_MINUS);              // bare sign at terminator
        send_text();
        text.push_back(CHAR_PLUS);
        text.push_back(8'h00);                   // sign then a non-digit
        send_text();
        text.push_back(8'hFF);                   // stray character
        send_text();
        send_text();                             // empty string
        put_str("4294967296");
        send_text();
        // mode flips in the middle of a string
        put_str("5 6");
        foreach (text[i])
            send_beat(text[i], 1'b0);
        text.delete();
        settle();
        write_mode(1'b1);
        send_beat(8'($urandom), 1'b1);
        text.push_back(CHAR_SPACE);              // whitespace only in single mode
        send_text();

        base     = beats;
        single   = 1'b1;
        phase_no = 0;
        while (beats - base < ITEMS) begin
            settle();
            single = ~single;
            write_mode(single);
            if (phase_no == 1)
                hold_req = 1'b1;
            if (!single && !long_done) begin
                put_long_list(MAX_VALUES_DEF + 1);
                send_text();
                long_done = 1'b1;
            end
            phase_len = $urandom_range(60, 160);
            phase_len = beats + phase_len;
            while (beats < phase_len && beats - base < ITEMS) begin
                build_string(single);
                send_text();
            end
            phase_no++;
        end
        settle();

        $display("%0d strings, %0d ids over %0d byte beats in %0d mode phases",
                 n_strings, n_ids, beats, phase_no);
        $display("statuses seen ok/syntax/range/count: %0b/%0b/%0b/%0b",
                 status_seen[ST_OK], status_seen[ST_SYNTAX], status_seen[ST_RANGE],
                 status_seen[ST_COUNT]);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
